FILE: hw/rtl/segment_intersection_assert.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

FILE: hw/rtl/si_pkg.sv
package si_pkg;

  // result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BOX      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PARALLEL = 2'd3;

  // configuration registers
  localparam int unsigned PTOL_W     = 16;
  localparam int unsigned CTOL_W     = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_TOL = 2'd1;

endpackage

FILE: hw/rtl/si_if.sv
interface si_in_if #(parameter int CW = 24) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] other_start_x;
  logic signed [CW-1:0] other_start_y;
  logic signed [CW-1:0] other_end_x;
  logic signed [CW-1:0] other_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           other_start_x, other_start_y, other_end_x, other_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           other_start_x, other_start_y, other_end_x, other_end_y,
    output ready
  );
endinterface

interface si_out_if #(parameter int CW = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [CW-1:0]          line_param;
  logic signed [CW-1:0]          cross_x;
  logic signed [CW-1:0]          cross_y;
  logic [si_pkg::STATUS_W-1:0]   status;

  modport source (output valid, line_param, cross_x, cross_y, status, input ready);
  modport sink   (input valid, line_param, cross_x, cross_y, status, output ready);
endinterface

FILE: hw/rtl/si_front.sv
module si_front #(
  parameter int CW  = 24,
  parameter int PFB = 16,
  localparam int DW = CW + 1,
  localparam int PW = 2 * CW + 2,
  localparam int NW = 2 * CW + 3,
  localparam int NB = NW + PFB,
  localparam int SW = 8 * CW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] fsx_i,
  input  logic signed [CW-1:0] fsy_i,
  input  logic signed [CW-1:0] fex_i,
  input  logic signed [CW-1:0] fey_i,
  input  logic signed [CW-1:0] osx_i,
  input  logic signed [CW-1:0] osy_i,
  input  logic signed [CW-1:0] oex_i,
  input  logic signed [CW-1:0] oey_i,
  output logic                 valid_o,
  output logic [NB-1:0]        num_o,
  output logic [NW-1:0]        den_o,
  output logic                 neg_o,
  output logic                 zero_o,
  output logic [SW-1:0]        side_o
);

  // endpoint ordering
  logic                 swap;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [CW-1:0] xmin, xmax, ymin, ymax;
  logic signed [DW-1:0] sx_d, sy_d;

  assign swap = (fsx_i == fex_i) ? !(fsy_i < fey_i) : !(fsx_i < fex_i);
  assign ax   = swap ? fex_i : fsx_i;
  assign ay   = swap ? fey_i : fsy_i;
  assign bx   = swap ? fsx_i : fex_i;
  assign by   = swap ? fsy_i : fey_i;
  assign xmin = (osx_i < oex_i) ? osx_i : oex_i;
  assign xmax = (osx_i > oex_i) ? osx_i : oex_i;
  assign ymin = (osy_i < oey_i) ? osy_i : oey_i;
  assign ymax = (osy_i > oey_i) ? osy_i : oey_i;
  assign sx_d = DW'(ax) - DW'(bx);
  assign sy_d = DW'(ay) - DW'(by);

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic signed [DW-1:0] sx1_q, sy1_q, bdy1_q, cdx1_q, bdx1_q, cdy1_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [NW-1:0] num3_q, den3_q;
  logic [NW-1:0]        nmag, dmag;
  logic [SW-1:0]        side1_q, side2_q, side3_q, side4_q;
  logic [NB-1:0]        num4_q;
  logic [NW-1:0]        den4_q;
  logic                 neg4_q, zero4_q;

  assign nmag = num3_q[NW-1] ? NW'(-num3_q) : NW'(num3_q);
  assign dmag = den3_q[NW-1] ? NW'(-den3_q) : NW'(den3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // differences
      sx1_q   <= sx_d;
      sy1_q   <= sy_d;
      bdy1_q  <= DW'(by) - DW'(oey_i);
      cdx1_q  <= DW'(osx_i) - DW'(oex_i);
      bdx1_q  <= DW'(bx) - DW'(oex_i);
      cdy1_q  <= DW'(osy_i) - DW'(oey_i);
      side1_q <= {bx, by, sx_d, sy_d, xmin, xmax, ymin, ymax};
      // cross products
      p1_q    <= PW'(bdy1_q) * PW'(cdx1_q);
      p2_q    <= PW'(bdx1_q) * PW'(cdy1_q);
      p3_q    <= PW'(sx1_q) * PW'(cdy1_q);
      p4_q    <= PW'(sy1_q) * PW'(cdx1_q);
      side2_q <= side1_q;
      // numerator and denominator
      num3_q  <= NW'(p1_q) - NW'(p2_q);
      den3_q  <= NW'(p3_q) - NW'(p4_q);
      side3_q <= side2_q;
      // magnitudes, numerator scaled by the fraction bits
      num4_q  <= NB'(nmag) << PFB;
      den4_q  <= dmag;
      neg4_q  <= num3_q[NW-1] ^ den3_q[NW-1];
      zero4_q <= (den3_q == '0);
      side4_q <= side3_q;
    end
  end

  assign valid_o = v4_q;
  assign num_o   = num4_q;
  assign den_o   = den4_q;
  assign neg_o   = neg4_q;
  assign zero_o  = zero4_q;
  assign side_o  = side4_q;

endmodule

FILE: hw/rtl/si_div.sv
module si_div #(
  parameter int CW  = 24,
  parameter int PFB = 16,
  localparam int NW = 2 * CW + 3,
  localparam int NB = NW + PFB,
  localparam int QB = CW + PFB + 3,
  localparam int SW = 8 * CW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NB-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  logic          neg_i,
  input  logic          zero_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quo_o,
  output logic          ovf_o,
  output logic          neg_o,
  output logic          zero_o,
  output logic [SW-1:0] side_o
);

  // one quotient bit per stage, most significant first
  logic          v_q    [0:QB];
  logic [QB-1:0] q_q    [0:QB];
  logic          ovf_q  [0:QB];
  logic          neg_q  [0:QB];
  logic          zero_q [0:QB];
  logic [SW-1:0] side_q [0:QB];
  logic [NB-1:0] r_q    [0:QB-1];
  logic [NW-1:0] d_q    [0:QB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= num_i;
      d_q[0]    <= den_i;
      q_q[0]    <= '0;
      // quotient would not fit: saturate later
      ovf_q[0]  <= (num_i >> QB) >= NB'(den_i);
      neg_q[0]  <= neg_i;
      zero_q[0] <= zero_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic          ge;

    assign ge  = (r_q[k] >> SH) >= NB'(d_q[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]    <= ge ? (q_q[k] | (QB'(1) << SH)) : q_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    if (k < QB - 1) begin : g_rem
      logic [NB-1:0] dsh;

      assign dsh = NB'(d_q[k]) << SH;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k+1] <= ge ? (r_q[k] - dsh) : r_q[k];
          d_q[k+1] <= d_q[k];
        end
      end
    end
  end

  assign valid_o = v_q[QB];
  assign quo_o   = q_q[QB];
  assign ovf_o   = ovf_q[QB];
  assign neg_o   = neg_q[QB];
  assign zero_o  = zero_q[QB];
  assign side_o  = side_q[QB];

endmodule

FILE: hw/rtl/si_back.sv
module si_back #(
  parameter int CW   = 24,
  parameter int PFB  = 16,
  localparam int DW  = CW + 1,
  localparam int QB  = CW + PFB + 3,
  localparam int TW  = QB + 1,
  localparam int TL  = (QB + 1) / 2,
  localparam int TH  = QB - TL,
  localparam int MXW = QB + CW - PFB,
  localparam int PXW = MXW + 2,
  localparam int SW  = 8 * CW + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [QB-1:0]                 quo_i,
  input  logic                          ovf_i,
  input  logic                          neg_i,
  input  logic                          zero_i,
  input  logic [SW-1:0]                 side_i,
  input  logic [si_pkg::PTOL_W-1:0]     ptol_i,
  input  logic [si_pkg::CTOL_W-1:0]     ctol_i,
  output logic                          valid_o,
  output logic signed [CW-1:0]          line_param_o,
  output logic signed [CW-1:0]          cross_x_o,
  output logic signed [CW-1:0]          cross_y_o,
  output logic [si_pkg::STATUS_W-1:0]   status_o
);

  localparam logic signed [PXW-1:0] PX_MAX = $signed({{(PXW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [PXW-1:0] PX_MIN = ~PX_MAX;
  localparam logic signed [TW-1:0]  T_MAX  = $signed({{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [TW-1:0]  T_MIN  = ~T_MAX;
  localparam logic signed [TW-1:0]  T_ONE  = $signed(TW'(1) << PFB);

  logic signed [CW-1:0] bx, by, xmin, xmax, ymin, ymax;
  logic signed [DW-1:0] sx, sy;
  logic [QB-1:0]        qm;

  assign {bx, by, sx, sy, xmin, xmax, ymin, ymax} = side_i;
  assign qm = ovf_i ? '1 : quo_i;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [QB-1:0]        qm1_q;
  logic signed [TW-1:0] tq1_q, tq2_q, tq3_q, tq4_q;
  logic [CW-1:0]        sxm1_q, sym1_q;
  logic                 sgx1_q, sgy1_q, sgx2_q, sgy2_q, sgx3_q, sgy3_q;
  logic                 z1_q, z2_q, z3_q, z4_q;
  logic [6*CW-1:0]      sb1_q, sb2_q, sb3_q, sb4_q;
  logic [TL+CW-1:0]     plx2_q, ply2_q;
  logic [TH+CW-1:0]     phx2_q, phy2_q;
  logic [QB+CW-1:0]     mx, my;
  logic [MXW-1:0]       mxs3_q, mys3_q;
  logic signed [PXW-1:0] px4_q, py4_q;

  // partial products recombined, then scaled down by the fraction bits
  assign mx = ((QB+CW)'(phx2_q) << TL) + (QB+CW)'(plx2_q);
  assign my = ((QB+CW)'(phy2_q) << TL) + (QB+CW)'(ply2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // signed t and direction magnitudes
      qm1_q  <= qm;
      tq1_q  <= neg_i ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      sxm1_q <= sx[DW-1] ? CW'(-sx) : CW'(sx);
      sym1_q <= sy[DW-1] ? CW'(-sy) : CW'(sy);
      sgx1_q <= neg_i ^ sx[DW-1];
      sgy1_q <= neg_i ^ sy[DW-1];
      z1_q   <= zero_i;
      sb1_q  <= {bx, by, xmin, xmax, ymin, ymax};
      // split multiply of t by the direction
      plx2_q <= (TL+CW)'(qm1_q[TL-1:0]) * (TL+CW)'(sxm1_q);
      phx2_q <= (TH+CW)'(qm1_q[QB-1:TL]) * (TH+CW)'(sxm1_q);
      ply2_q <= (TL+CW)'(qm1_q[TL-1:0]) * (TL+CW)'(sym1_q);
      phy2_q <= (TH+CW)'(qm1_q[QB-1:TL]) * (TH+CW)'(sym1_q);
      tq2_q  <= tq1_q;
      sgx2_q <= sgx1_q;
      sgy2_q <= sgy1_q;
      z2_q   <= z1_q;
      sb2_q  <= sb1_q;
      // sum of partial products
      mxs3_q <= MXW'(mx >> PFB);
      mys3_q <= MXW'(my >> PFB);
      tq3_q  <= tq2_q;
      sgx3_q <= sgx2_q;
      sgy3_q <= sgy2_q;
      z3_q   <= z2_q;
      sb3_q  <= sb2_q;
      // add back the base endpoint
      px4_q  <= PXW'($signed(sb3_q[6*CW-1 -: CW])) +
                (sgx3_q ? -$signed({2'b00, mxs3_q}) : $signed({2'b00, mxs3_q}));
      py4_q  <= PXW'($signed(sb3_q[5*CW-1 -: CW])) +
                (sgy3_q ? -$signed({2'b00, mys3_q}) : $signed({2'b00, mys3_q}));
      tq4_q  <= tq3_q;
      z4_q   <= z3_q;
      sb4_q  <= sb3_q;
    end
  end

  // range and box checks
  logic signed [TW-1:0]  ptl, t_lo, t_hi;
  logic signed [PXW-1:0] ctl, x_lo, x_hi, y_lo, y_hi;
  logic                  out_range, out_box;
  logic signed [CW-1:0]  t_sat, x_sat, y_sat;

  assign ptl  = $signed(TW'(ptol_i));
  assign t_lo = -ptl;
  assign t_hi = T_ONE + ptl;
  assign ctl  = $signed(PXW'(ctol_i));
  assign x_lo = PXW'($signed(sb4_q[4*CW-1 -: CW])) - ctl;
  assign x_hi = PXW'($signed(sb4_q[3*CW-1 -: CW])) + ctl;
  assign y_lo = PXW'($signed(sb4_q[2*CW-1 -: CW])) - ctl;
  assign y_hi = PXW'($signed(sb4_q[CW-1:0])) + ctl;

  assign out_range = (tq4_q < t_lo) || (tq4_q > t_hi);
  assign out_box   = (px4_q < x_lo) || (px4_q > x_hi) || (py4_q < y_lo) || (py4_q > y_hi);

  assign t_sat = (tq4_q > T_MAX) ? T_MAX[CW-1:0] :
                 (tq4_q < T_MIN) ? T_MIN[CW-1:0] : tq4_q[CW-1:0];
  assign x_sat = (px4_q > PX_MAX) ? PX_MAX[CW-1:0] :
                 (px4_q < PX_MIN) ? PX_MIN[CW-1:0] : px4_q[CW-1:0];
  assign y_sat = (py4_q > PX_MAX) ? PX_MAX[CW-1:0] :
                 (py4_q < PX_MIN) ? PX_MIN[CW-1:0] : py4_q[CW-1:0];

  always_comb begin
    line_param_o = t_sat;
    cross_x_o    = x_sat;
    cross_y_o    = y_sat;
    if (z4_q) begin
      line_param_o = '0;
      cross_x_o    = '0;
      cross_y_o    = '0;
      status_o     = si_pkg::ST_PARALLEL;
    end else if (out_range) begin
      status_o = si_pkg::ST_RANGE;
    end else if (out_box) begin
      status_o = si_pkg::ST_BOX;
    end else begin
      status_o = si_pkg::ST_HIT;
    end
  end

  assign valid_o = v4_q;

endmodule

FILE: hw/rtl/segment_intersection.sv
// channel  | dir | fields                                        | transfer
// in_i     | in  | first/other segment start/end x and y, Q15.8  | valid && ready
// out_o    | out | line_param Q7.16, cross_x/y Q15.8, status     | valid && ready
// cfg      | in  | cfg_idx_i, cfg_data_i (0 param tol, 1 coord)   | cfg_we_i
//
// one item per cycle sustained while the output is not stalled; the restoring
// divider sets the pipeline depth, with one quotient bit per stage
// reset clears all valid bits and both tolerance registers to zero
// a stalled result holds in the output register; the whole pipeline then
// freezes, so nothing is lost or repeated, and bubbles leave as soon as ready returns
module segment_intersection #(
  parameter int COORD_WIDTH     = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  si_in_if.sink                          in_i,
  si_out_if.source                       out_o,
  input  logic                           cfg_we_i,
  input  logic [si_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [si_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = 2 * CW + 3;
  localparam int NB = NW + PARAM_FRAC_BITS;
  localparam int QB = CW + PARAM_FRAC_BITS + 3;
  localparam int SW = 8 * CW + 2;

  // configuration registers
  logic [si_pkg::PTOL_W-1:0] ptol_q;
  logic [si_pkg::CTOL_W-1:0] ctol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptol_q <= '0;
      ctol_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        si_pkg::REG_PARAM_TOL: ptol_q <= cfg_data_i[si_pkg::PTOL_W-1:0];
        si_pkg::REG_COORD_TOL: ctol_q <= cfg_data_i[si_pkg::CTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is stuck
  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // front end: ordering, cross products, magnitudes
  logic          f_valid, f_neg, f_zero;
  logic [NB-1:0] f_num;
  logic [NW-1:0] f_den;
  logic [SW-1:0] f_side;

  si_front #(.CW(CW), .PFB(PARAM_FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .fsx_i   (in_i.first_start_x),
    .fsy_i   (in_i.first_start_y),
    .fex_i   (in_i.first_end_x),
    .fey_i   (in_i.first_end_y),
    .osx_i   (in_i.other_start_x),
    .osy_i   (in_i.other_start_y),
    .oex_i   (in_i.other_end_x),
    .oey_i   (in_i.other_end_y),
    .valid_o (f_valid),
    .num_o   (f_num),
    .den_o   (f_den),
    .neg_o   (f_neg),
    .zero_o  (f_zero),
    .side_o  (f_side)
  );

  // pipelined divider for t
  logic          d_valid, d_ovf, d_neg, d_zero;
  logic [QB-1:0] d_quo;
  logic [SW-1:0] d_side;

  si_div #(.CW(CW), .PFB(PARAM_FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .neg_i   (f_neg),
    .zero_i  (f_zero),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .ovf_o   (d_ovf),
    .neg_o   (d_neg),
    .zero_o  (d_zero),
    .side_o  (d_side)
  );

  // back end: point, saturation and status
  logic                        b_valid;
  logic signed [CW-1:0]        b_param, b_x, b_y;
  logic [si_pkg::STATUS_W-1:0] b_status;

  si_back #(.CW(CW), .PFB(PARAM_FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (d_valid),
    .quo_i        (d_quo),
    .ovf_i        (d_ovf),
    .neg_i        (d_neg),
    .zero_i       (d_zero),
    .side_i       (d_side),
    .ptol_i       (ptol_q),
    .ctol_i       (ctol_q),
    .valid_o      (b_valid),
    .line_param_o (b_param),
    .cross_x_o    (b_x),
    .cross_y_o    (b_y),
    .status_o     (b_status)
  );

  // output register
  logic signed [CW-1:0]        param_q, x_q, y_q;
  logic [si_pkg::STATUS_W-1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      param_q  <= b_param;
      x_q      <= b_x;
      y_q      <= b_y;
      status_q <= b_status;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.line_param = param_q;
  assign out_o.cross_x    = x_q;
  assign out_o.cross_y    = y_q;
  assign out_o.status     = status_q;

endmodule

FILE: hw/rtl/si_checker.sv
`include "segment_intersection_assert.svh"

module si_checker #(
  parameter int CW = 24
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [CW-1:0]        line_param_i,
  input logic signed [CW-1:0]        cross_x_i,
  input logic signed [CW-1:0]        cross_y_i,
  input logic [si_pkg::STATUS_W-1:0] status_i
);

  logic par_out;
  logic fields_zero;

  assign par_out     = out_valid_i && (status_i == si_pkg::ST_PARALLEL);
  assign fields_zero = (line_param_i == '0) && (cross_x_i == '0) && (cross_y_i == '0);

  // input side only stalls behind a blocked result
  `SI_ASSERT_NOW(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)

  // parallel results carry zero fields
  `SI_ASSERT_NOW(a_parallel_zero, par_out, fields_zero)

  // a blocked result holds
  `SI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(line_param_i))

endmodule

bind segment_intersection si_checker #(.CW(COORD_WIDTH)) u_si_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_param_i (out_o.line_param),
  .cross_x_i    (out_o.cross_x),
  .cross_y_i    (out_o.cross_y),
  .status_i     (out_o.status)
);
